/* src/sbd_pkg.sv */
// Shared types and constants of the sharer bitmap directory.
package sbd_pkg;

    localparam int ADDR_W = 64;
    localparam int VEC_W = 64;
    localparam int NODE_W = 6;
    localparam int NCNT_W = 7;
    localparam int LCNT_W = 17;
    localparam int SHIFT_W = 4;
    localparam int LIDX_W = 32;
    localparam int ACT_W = 3;
    localparam int STAT_W = 3;
    localparam int LINES_W = 21;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 64;
    localparam int IN_DATA_W = 168;
    localparam int OUT_DATA_W = 136;

    localparam logic [ACT_W-1:0] ACT_READ = 3'd0;
    localparam logic [ACT_W-1:0] ACT_WRITE = 3'd1;
    localparam logic [ACT_W-1:0] ACT_TEST = 3'd2;
    localparam logic [ACT_W-1:0] ACT_UPDATE = 3'd3;
    localparam logic [ACT_W-1:0] ACT_ADDRESS = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK = 3'd0;
    localparam logic [STAT_W-1:0] ST_BAD_ADDRESS = 3'd1;
    localparam logic [STAT_W-1:0] ST_BAD_NODE = 3'd2;
    localparam logic [STAT_W-1:0] ST_BAD_MASK = 3'd3;
    localparam logic [STAT_W-1:0] ST_BAD_INDEX = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SHIFT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NODES = 2'd3;

    typedef struct packed {
        logic clear;
        logic accept;
        logic check;
        logic locate;
        logic load;
    } dir_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic out_free;
    } dir_sts_t;

endpackage

/* src/sbd_ctrl.sv */
// Sequencing state machine of the sharer bitmap directory.
module sbd_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  sbd_pkg::dir_sts_t sts,
    output sbd_pkg::dir_cmd_t cmd
);
    import sbd_pkg::*;

    typedef enum logic [5:0] {
        S_CLEAR  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_CHECK  = 6'b000100,
        S_LOCATE = 6'b001000,
        S_READ   = 6'b010000,
        S_LOAD   = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (sts.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                cmd.check = 1'b1;
                state_next = S_LOCATE;
            end
            S_LOCATE:
            begin
                cmd.locate = 1'b1;
                state_next = S_READ;
            end
            S_READ:
            begin
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                if (sts.out_free)
                begin
                    cmd.load = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

endmodule

/* src/sbd_datapath.sv */
// Configuration registers, address checks, sharer store and result register.
module sbd_datapath #(
    parameter int MAX_LINES = 65536,
    parameter int MAX_NODES = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [sbd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sbd_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic [sbd_pkg::ACT_W-1:0]        action,
    input  logic [sbd_pkg::ADDR_W-1:0]       address,
    input  logic [sbd_pkg::NODE_W-1:0]       node,
    input  logic                             present,
    input  logic [sbd_pkg::VEC_W-1:0]        new_mask,
    input  logic [sbd_pkg::LIDX_W-1:0]       line_index,
    input  logic                             m_tready,
    output logic                             m_tvalid,
    output logic [sbd_pkg::VEC_W-1:0]        sharer_vector,
    output logic                             node_present,
    output logic [sbd_pkg::ADDR_W-1:0]       line_address,
    output logic [sbd_pkg::STAT_W-1:0]       status,
    input  sbd_pkg::dir_cmd_t                cmd,
    output sbd_pkg::dir_sts_t                sts
);
    import sbd_pkg::*;

    localparam int IDX_W = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
    localparam logic [LINES_W-1:0] LINE_CAP = LINES_W'(MAX_LINES);
    localparam logic [NCNT_W-1:0] NODE_CAP = NCNT_W'(MAX_NODES);
    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(MAX_LINES - 1);

    logic [ADDR_W-1:0]  base_reg;
    logic [LCNT_W-1:0]  lines_reg;
    logic [SHIFT_W-1:0] shift_reg;
    logic [NCNT_W-1:0]  nodes_reg;

    logic [ACT_W-1:0]   act_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [NODE_W-1:0]  node_reg;
    logic               present_reg;
    logic [VEC_W-1:0]   mask_reg;
    logic [LIDX_W-1:0]  lidx_reg;

    logic [ADDR_W-1:0]  offset_reg;
    logic               below_reg;
    logic [VEC_W-1:0]   vmask_reg;
    logic               bad_mask_reg;
    logic               bad_node_reg;
    logic               bad_index_reg;
    logic [ADDR_W-1:0]  addr_out_reg;

    logic [STAT_W-1:0]  status_reg;
    logic [IDX_W-1:0]   slot_reg;

    logic [IDX_W-1:0]   clr_cnt_reg;
    logic [MAX_NODES-1:0] mem [MAX_LINES];
    logic [MAX_NODES-1:0] rd_data_reg;

    logic               out_valid_reg;
    logic [VEC_W-1:0]   vec_out_reg;
    logic               bit_out_reg;
    logic [ADDR_W-1:0]  line_addr_out_reg;
    logic [STAT_W-1:0]  status_out_reg;

    logic [LINES_W-1:0] lines_eff;
    logic [NCNT_W-1:0]  nodes_eff;
    logic [VEC_W-1:0]   vmask;
    logic [ADDR_W:0]    diff;
    logic [ADDR_W-1:0]  low_mask;
    logic [ADDR_W-1:0]  line_idx;
    logic               addr_ok;
    logic [STAT_W-1:0]  status_next;
    logic               ok;
    logic [VEC_W-1:0]   cur;
    logic [VEC_W-1:0]   node_bit;
    logic [VEC_W-1:0]   wdata;
    logic               wr_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= '0;
            lines_reg <= LCNT_W'(65536);
            shift_reg <= SHIFT_W'(6);
            nodes_reg <= NCNT_W'(64);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_BASE:  base_reg <= cfg_data;
                CFG_LINES: lines_reg <= cfg_data[LCNT_W-1:0];
                CFG_SHIFT: shift_reg <= cfg_data[SHIFT_W-1:0];
                CFG_NODES: nodes_reg <= cfg_data[NCNT_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        lines_eff = (LINES_W'(lines_reg) > LINE_CAP) ? LINE_CAP : LINES_W'(lines_reg);
        nodes_eff = (nodes_reg > NODE_CAP) ? NODE_CAP : nodes_reg;
        for (int i = 0; i < VEC_W; i++)
        begin
            vmask[i] = (NCNT_W'(i) < nodes_eff);
        end
        diff = {1'b0, addr_reg} - {1'b0, base_reg};
        low_mask = ~({ADDR_W{1'b1}} << shift_reg);
        line_idx = offset_reg >> shift_reg;
        addr_ok = !below_reg && ((offset_reg & low_mask) == '0)
                  && (line_idx < ADDR_W'(lines_eff));
    end

    always_comb
    begin
        unique case (act_reg)
            ACT_READ:    status_next = addr_ok ? ST_OK : ST_BAD_ADDRESS;
            ACT_WRITE:   status_next = bad_mask_reg ? ST_BAD_MASK
                                     : (addr_ok ? ST_OK : ST_BAD_ADDRESS);
            ACT_TEST,
            ACT_UPDATE:  status_next = bad_node_reg ? ST_BAD_NODE
                                     : (addr_ok ? ST_OK : ST_BAD_ADDRESS);
            ACT_ADDRESS: status_next = bad_index_reg ? ST_BAD_INDEX : ST_OK;
            default:     status_next = ST_OK;
        endcase
    end

    // Request capture and the two check stages.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            act_reg <= action;
            addr_reg <= address;
            node_reg <= node;
            present_reg <= present;
            mask_reg <= new_mask;
            lidx_reg <= line_index;
        end
        if (cmd.check)
        begin
            offset_reg <= diff[ADDR_W-1:0];
            below_reg <= diff[ADDR_W];
            vmask_reg <= vmask;
            bad_mask_reg <= |(mask_reg & ~vmask);
            bad_node_reg <= ({1'b0, node_reg} >= nodes_eff);
            bad_index_reg <= !(ADDR_W'(lidx_reg) < ADDR_W'(lines_eff));
            addr_out_reg <= base_reg + (ADDR_W'(lidx_reg) << shift_reg);
        end
        if (cmd.locate)
        begin
            status_reg <= status_next;
            slot_reg <= line_idx[IDX_W-1:0];
        end
    end

    always_comb
    begin
        ok = (status_reg == ST_OK);
        cur = VEC_W'(rd_data_reg) & vmask_reg;
        node_bit = VEC_W'(1) << node_reg;
        if (act_reg == ACT_WRITE)
        begin
            wdata = mask_reg & vmask_reg;
        end
        else if (present_reg)
        begin
            wdata = (cur | node_bit) & vmask_reg;
        end
        else
        begin
            wdata = cur & ~node_bit;
        end
        wr_en = cmd.load && ok && ((act_reg == ACT_WRITE) || (act_reg == ACT_UPDATE));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clear)
        begin
            clr_cnt_reg <= clr_cnt_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clear)
        begin
            mem[clr_cnt_reg] <= '0;
        end
        else if (wr_en)
        begin
            mem[slot_reg] <= wdata[MAX_NODES-1:0];
        end
        rd_data_reg <= mem[slot_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            vec_out_reg <= (ok && (act_reg == ACT_READ)) ? cur : '0;
            bit_out_reg <= ok && (act_reg == ACT_TEST) && cur[node_reg];
            line_addr_out_reg <= (ok && (act_reg == ACT_ADDRESS)) ? addr_out_reg : '0;
            status_out_reg <= status_reg;
        end
    end

    assign sts.clear_last = (clr_cnt_reg == LAST_SLOT);
    assign sts.out_free = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign sharer_vector = vec_out_reg;
    assign node_present = bit_out_reg;
    assign line_address = line_addr_out_reg;
    assign status = status_out_reg;

endmodule

/* src/sharer_bitmap_directory_top.sv */
// Top level of the sharer bitmap directory.
// A full-map coherence directory holding one sharer vector per line of a
// configured address range. After reset the block sweeps the sharer store
// to zero, one line per cycle, while s_tready stays low; configuration
// writes are taken at any time. Each request then passes from acceptance
// through the check and locate states of range and alignment checks and a
// state for the registered read of the store to the load state, in which
// the result register is loaded and, for write and update requests that
// pass their checks, the store is written. The result register lets the
// next request be accepted while a result still waits; a request that reaches
// its load state while the previous result is still held waits there until
// m_tready takes that result.
module sharer_bitmap_directory_top #(
    parameter int MAX_LINES = 65536,
    parameter int MAX_NODES = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [sbd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sbd_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // address, node, present, new_mask, line_index, zero pad
    input  logic [sbd_pkg::IN_DATA_W-1:0]    s_tdata,
    // action
    input  logic [sbd_pkg::ACT_W-1:0]        s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // sharer_vector, node_present, line_address, status, zero pad
    output logic [sbd_pkg::OUT_DATA_W-1:0]   m_tdata
);
    import sbd_pkg::*;

    dir_cmd_t cmd;
    dir_sts_t sts;

    logic [VEC_W-1:0]  sharer_vector;
    logic              node_present;
    logic [ADDR_W-1:0] line_address;
    logic [STAT_W-1:0] status;

    sbd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    sbd_datapath #(
        .MAX_LINES (MAX_LINES),
        .MAX_NODES (MAX_NODES)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .action        (s_tuser),
        .address       (s_tdata[63:0]),
        .node          (s_tdata[69:64]),
        .present       (s_tdata[70]),
        .new_mask      (s_tdata[134:71]),
        .line_index    (s_tdata[166:135]),
        .m_tready      (m_tready),
        .m_tvalid      (m_tvalid),
        .sharer_vector (sharer_vector),
        .node_present  (node_present),
        .line_address  (line_address),
        .status        (status),
        .cmd           (cmd),
        .sts           (sts)
    );

    assign m_tdata = {4'b0000, status, line_address, node_present, sharer_vector};

endmodule
